// ===== rtl/core/rvenc_pkg.sv =====
`default_nettype none

package rvenc_pkg;

  typedef enum logic [3:0] {
    REQ_WIDE   = 4'd0,
    REQ_LI     = 4'd1,
    REQ_RET    = 4'd2,
    REQ_R      = 4'd3,
    REQ_I      = 4'd4,
    REQ_S      = 4'd5,
    REQ_U      = 4'd6,
    REQ_BRANCH = 4'd7,
    REQ_JUMP   = 4'd8
  } req_type_e;

  localparam logic [6:0] OPC_WIDE   = 7'h3f;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [4:0] REG_ZERO   = 5'd0;
  localparam logic [4:0] REG_RA     = 5'd1;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned BYTE_IDX_W = 3;
  localparam logic [BYTE_IDX_W-1:0] LAST_IDX_WIDE = 3'd7;
  localparam logic [BYTE_IDX_W-1:0] LAST_IDX_STD  = 3'd3;
  localparam logic [BYTE_IDX_W-1:0] LAST_IDX_ERR  = 3'd0;

  typedef struct packed {
    logic [63:0] word;
    logic        wide;
    logic        err;
  } enc_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/rvenc_if.sv =====
`default_nettype none

interface rvenc_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [6:0]  opcode;
  logic [2:0]  funct3;
  logic [6:0]  funct7;
  logic [5:0]  rd_reg;
  logic [5:0]  rs1_reg;
  logic [5:0]  rs2_reg;
  logic [5:0]  acc_reg;
  logic [63:0] immediate;
  logic        label_pending;
  logic [7:0]  operation;
  logic [15:0] dtype;

  modport source (
    output valid, req_type, opcode, funct3, funct7, rd_reg, rs1_reg, rs2_reg, acc_reg,
           immediate, label_pending, operation, dtype,
    input  ready
  );
  modport sink (
    input  valid, req_type, opcode, funct3, funct7, rd_reg, rs1_reg, rs2_reg, acc_reg,
           immediate, label_pending, operation, dtype,
    output ready
  );
endinterface

interface rvenc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, out_byte, last, error, input ready);
  modport sink (input valid, out_byte, last, error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rvenc_front.sv =====
`default_nettype none

module rvenc_front
  import rvenc_pkg::*;
(
  rvenc_req_if.sink   req_i,
  input  wire logic   full_i,
  output enc_entry_t  entry_o,
  output logic        push_o
);

  logic [4:0]  rd, rs1, rs2, acc;
  logic        rd_g, rs1_g, rs2_g;
  logic        all_vec;
  logic        fit12, fit20, fit13, fit21, even;
  logic [63:0] imm;
  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;

  assign rd  = req_i.rd_reg[4:0];
  assign rs1 = req_i.rs1_reg[4:0];
  assign rs2 = req_i.rs2_reg[4:0];
  assign acc = req_i.acc_reg[4:0];
  assign rd_g  = ~req_i.rd_reg[5];
  assign rs1_g = ~req_i.rs1_reg[5];
  assign rs2_g = ~req_i.rs2_reg[5];
  assign all_vec = req_i.rd_reg[5] & req_i.rs1_reg[5] & req_i.rs2_reg[5] & req_i.acc_reg[5];
  assign imm = req_i.immediate;
  assign op  = req_i.opcode;
  assign f3  = req_i.funct3;
  assign f7  = req_i.funct7;

  // signed fit: all bits above the sign position equal the sign
  assign fit12 = (&imm[63:11]) | ~(|imm[63:11]);
  assign fit20 = (&imm[63:19]) | ~(|imm[63:19]);
  assign fit13 = (&imm[63:12]) | ~(|imm[63:12]);
  assign fit21 = (&imm[63:20]) | ~(|imm[63:20]);
  assign even  = ~imm[0];

  assign req_i.ready = ~full_i;
  assign push_o      = req_i.valid & ~full_i;

  always_comb begin
    entry_o = '0;
    unique case (req_type_e'(req_i.req_type))
      REQ_WIDE: begin
        entry_o.wide = 1'b1;
        entry_o.err  = ~all_vec;
        entry_o.word = {req_i.dtype, 3'd0, acc, req_i.operation, f7, rs2, rs1, 3'd0, rd,
                        OPC_WIDE};
      end
      REQ_LI: begin
        entry_o.err  = ~(rd_g & fit12);
        entry_o.word = {32'd0, imm[11:0], REG_ZERO, 3'd0, rd, OPC_OP_IMM};
      end
      REQ_RET: begin
        entry_o.word = {32'd0, 12'd0, REG_RA, 3'd0, REG_ZERO, OPC_JALR};
      end
      REQ_R: begin
        entry_o.err  = ~(rd_g & rs1_g & rs2_g);
        entry_o.word = {32'd0, f7, rs2, rs1, f3, rd, op};
      end
      REQ_I: begin
        entry_o.err  = ~(rd_g & rs1_g & fit12);
        entry_o.word = {32'd0, imm[11:0], rs1, f3, rd, op};
      end
      REQ_S: begin
        entry_o.err  = ~(rs1_g & rs2_g & fit12);
        entry_o.word = {32'd0, imm[11:5], rs2, rs1, f3, imm[4:0], op};
      end
      REQ_U: begin
        entry_o.err  = ~(rd_g & fit20);
        entry_o.word = {32'd0, imm[19:0], rd, op};
      end
      REQ_BRANCH: begin
        entry_o.err  = req_i.label_pending | ~(rs1_g & rs2_g & even & fit13);
        entry_o.word = {32'd0, imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11],
                        OPC_BRANCH};
      end
      REQ_JUMP: begin
        entry_o.err  = req_i.label_pending | ~(rd_g & even & fit21);
        entry_o.word = {32'd0, imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
      end
      default: begin
        entry_o.err = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/rvenc_queue.sv =====
`default_nettype none

module rvenc_queue
  import rvenc_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire enc_entry_t  entry_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output enc_entry_t       head_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  enc_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rvenc_back.sv =====
`default_nettype none

module rvenc_back
  import rvenc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire enc_entry_t   head_i,
  input  wire logic         empty_i,
  output logic              pop_o,
  rvenc_byte_if.source      rsp_o
);

  logic [BYTE_IDX_W-1:0] idx_q, idx_d, last_idx;
  logic                  valid_q, valid_d;
  logic [7:0]            byte_q, byte_d;
  logic                  last_q, last_d;
  logic                  err_q, err_d;
  logic                  load, is_last;
  logic [7:0]            sel_byte;

  assign sel_byte = head_i.word[{idx_q, 3'b000} +: 8];
  assign last_idx = head_i.err ? LAST_IDX_ERR : (head_i.wide ? LAST_IDX_WIDE : LAST_IDX_STD);
  assign is_last  = (idx_q == last_idx);
  assign load     = ~empty_i & (~valid_q | rsp_o.ready);
  assign pop_o    = load & is_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    err_d   = err_q;
    if (load) begin
      valid_d = 1'b1;
      byte_d  = head_i.err ? 8'd0 : sel_byte;
      last_d  = is_last;
      err_d   = head_i.err;
      idx_d   = is_last ? '0 : idx_q + 1'b1;
    end else if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    err_q  <= err_d;
  end

  assign rsp_o.valid    = valid_q;
  assign rsp_o.out_byte = byte_q;
  assign rsp_o.last     = last_q;
  assign rsp_o.error    = err_q;

endmodule

`default_nettype wire

// ===== rtl/core/rv64_instruction_word_encoder.sv =====
`default_nettype none

// RV64 instruction word encoder. Each parsed instruction on req_i is checked
// (register banks, immediate ranges, pending labels) and packed into a 32-bit
// RISC-V word or a 64-bit wide custom word, then streamed on rsp_o as
// little-endian bytes, one byte per cycle while rsp_o.ready is high, with last
// on the final byte. A failed check gives a single zero byte with last and
// error set. The front end takes one instruction per cycle into a small queue
// while it is not full; the byte serializer sends four bytes per standard
// instruction, eight per wide custom instruction and one per error.
// Each entry goes through the queue memory, then the output byte register.
module rv64_instruction_word_encoder
  import rvenc_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  rvenc_req_if.sink     req_i,
  rvenc_byte_if.source  rsp_o
);

  enc_entry_t push_entry, head_entry;
  logic       push, pop, full, empty;

  rvenc_front u_front (
    .req_i   (req_i),
    .full_i  (full),
    .entry_o (push_entry),
    .push_o  (push)
  );

  rvenc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head_entry),
    .empty_o (empty)
  );

  rvenc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );

endmodule

`default_nettype wire

// ===== sim/rv64_instruction_word_encoder_tb.sv =====
`timescale 1ns / 100ps

module rv64_instruction_word_encoder_tb;
  import rvenc_pkg::*;

  localparam logic [3:0] REQ_UNDEF_LO = 4'd9;
  localparam logic [3:0] REQ_UNDEF_HI = 4'd15;
  localparam longint IMM12_MIN = -2048;
  localparam longint IMM12_MAX = 2047;
  localparam longint IMM20_MIN = -524288;
  localparam longint IMM20_MAX = 524287;
  localparam int RANDOM_ITEMS = 254;
  localparam int PRESSURE_AT = 100;
  localparam int QUIET_FROM = 214;
  localparam int LONG_HOLD = 60;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [3:0]  kind;
    logic [6:0]  opcode;
    logic [2:0]  funct3;
    logic [6:0]  funct7;
    logic [5:0]  rd;
    logic [5:0]  rs1;
    logic [5:0]  rs2;
    logic [5:0]  acc;
    logic [63:0] imm;
    logic        label_pending;
    logic [7:0]  operation;
    logic [15:0] dtype;
  } instr_t;

  typedef struct packed {
    instr_t      instr;
    logic        typed;
    logic [63:0] word;
    logic        err;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } enc_byte_t;

  logic clk_i;
  logic rst_ni;

  rvenc_req_if  req_if ();
  rvenc_byte_if rsp_if ();

  rv64_instruction_word_encoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  enc_byte_t expected_bytes[$];
  dir_row_t  dir_rows[$];
  int        fails;
  int        cycle_count;
  int        stall_left;
  bit        idle_en;
  bit        hold_req;

  function automatic bit out_of(input longint v, input longint lo, input longint hi);
    return (v < lo) || (v > hi);
  endfunction

  function automatic void add_row(input dir_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void encode_instr(input instr_t r, output logic [63:0] word,
                                       output int nbytes, output bit bad);
    longint s;
    s = r.imm;
    word = '0;
    nbytes = 4;
    bad = 1'b0;
    case (r.kind)
      REQ_WIDE: begin
        bad = !(r.rd[5] && r.rs1[5] && r.rs2[5] && r.acc[5]);
        word = {r.dtype, 3'b000, r.acc[4:0], r.operation, r.funct7, r.rs2[4:0],
                r.rs1[4:0], 3'b000, r.rd[4:0], OPC_WIDE};
        nbytes = 8;
      end
      REQ_LI: begin
        bad = r.rd[5] || out_of(s, IMM12_MIN, IMM12_MAX);
        word = {32'd0, r.imm[11:0], REG_ZERO, 3'b000, r.rd[4:0], OPC_OP_IMM};
      end
      REQ_RET: begin
        word = {32'd0, 12'd0, REG_RA, 3'b000, REG_ZERO, OPC_JALR};
      end
      REQ_R: begin
        bad = r.rd[5] || r.rs1[5] || r.rs2[5];
        word = {32'd0, r.funct7, r.rs2[4:0], r.rs1[4:0], r.funct3, r.rd[4:0], r.opcode};
      end
      REQ_I: begin
        bad = r.rd[5] || r.rs1[5] || out_of(s, IMM12_MIN, IMM12_MAX);
        word = {32'd0, r.imm[11:0], r.rs1[4:0], r.funct3, r.rd[4:0], r.opcode};
      end
      REQ_S: begin
        bad = r.rs1[5] || r.rs2[5] || out_of(s, IMM12_MIN, IMM12_MAX);
        word = {32'd0, r.imm[11:5], r.rs2[4:0], r.rs1[4:0], r.funct3, r.imm[4:0],
                r.opcode};
      end
      REQ_U: begin
        bad = r.rd[5] || out_of(s, IMM20_MIN, IMM20_MAX);
        word = {32'd0, r.imm[19:0], r.rd[4:0], r.opcode};
      end
      REQ_BRANCH: begin
        bad = r.label_pending || r.rs1[5] || r.rs2[5] || r.imm[0] ||
              out_of(s, IMM12_MIN * 2, IMM12_MAX * 2);
        word = {32'd0, r.imm[12], r.imm[10:5], r.rs2[4:0], r.rs1[4:0], r.funct3,
                r.imm[4:1], r.imm[11], OPC_BRANCH};
      end
      REQ_JUMP: begin
        bad = r.label_pending || r.rd[5] || r.imm[0] ||
              out_of(s, IMM20_MIN * 2, IMM20_MAX * 2);
        word = {32'd0, r.imm[20], r.imm[10:1], r.imm[11], r.imm[19:12], r.rd[4:0],
                OPC_JAL};
      end
      default: bad = 1'b1;
    endcase
  endfunction

  function automatic void queue_bytes(input logic [63:0] word, input int nbytes,
                                      input bit bad);
    enc_byte_t b;
    if (bad) begin
      b.data = 8'h00;
      b.last = 1'b1;
      b.err = 1'b1;
      expected_bytes.insert(expected_bytes.size(), b);
    end else begin
      for (int k = 0; k < nbytes; k++) begin
        b.data = word[8*k +: 8];
        b.last = (k == nbytes - 1);
        b.err = 1'b0;
        expected_bytes.insert(expected_bytes.size(), b);
      end
    end
  endfunction

  function automatic instr_t mk(input logic [3:0] kind, input logic [6:0] opcode,
                                input logic [2:0] f3, input logic [6:0] f7,
                                input logic [5:0] rd, input logic [5:0] rs1,
                                input logic [5:0] rs2, input logic [5:0] acc,
                                input logic [63:0] imm, input logic pend,
                                input logic [7:0] oper, input logic [15:0] dtype);
    instr_t r;
    r.kind = kind;
    r.opcode = opcode;
    r.funct3 = f3;
    r.funct7 = f7;
    r.rd = rd;
    r.rs1 = rs1;
    r.rs2 = rs2;
    r.acc = acc;
    r.imm = imm;
    r.label_pending = pend;
    r.operation = oper;
    r.dtype = dtype;
    return r;
  endfunction

  function automatic longint pick_imm(input longint lo, input longint hi, input int sel);
    if (sel == 0) return lo;
    if (sel == 1) return hi;
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  function automatic instr_t rand_instr();
    instr_t r;
    int sel;
    r.kind = ($urandom_range(0, 24) == 0) ? 4'($urandom_range(REQ_UNDEF_LO, REQ_UNDEF_HI))
                                          : 4'($urandom_range(REQ_WIDE, REQ_JUMP));
    r.opcode = 7'($urandom);
    r.funct3 = 3'($urandom);
    r.funct7 = 7'($urandom);
    r.rd = 6'($urandom);
    r.rs1 = 6'($urandom);
    r.rs2 = 6'($urandom);
    r.acc = 6'($urandom);
    r.imm = {$urandom, $urandom};
    r.label_pending = 1'($urandom);
    r.operation = 8'($urandom);
    r.dtype = 16'($urandom);
    sel = $urandom_range(0, 7);
    if ($urandom_range(0, 3) != 0) begin
      r.label_pending = 1'b0;
      if (r.kind == REQ_WIDE) begin
        r.rd[5] = 1'b1;
        r.rs1[5] = 1'b1;
        r.rs2[5] = 1'b1;
        r.acc[5] = 1'b1;
      end else begin
        r.rd[5] = 1'b0;
        r.rs1[5] = 1'b0;
        r.rs2[5] = 1'b0;
      end
      case (r.kind)
        REQ_LI, REQ_I, REQ_S: r.imm = pick_imm(IMM12_MIN, IMM12_MAX, sel);
        REQ_U:                r.imm = pick_imm(IMM20_MIN, IMM20_MAX, sel);
        REQ_BRANCH:           r.imm = pick_imm(IMM12_MIN, IMM12_MAX, sel) * 2;
        REQ_JUMP:             r.imm = pick_imm(IMM20_MIN, IMM20_MAX, sel) * 2;
        default: ;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        1: r.imm = pick_imm(IMM20_MIN * 4, IMM20_MAX * 4, 2);
        2: r.imm = pick_imm(-4100, 4100, 2);
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic send_instr(input instr_t r, input bit typed, input logic [63:0] tword,
                            input bit terr);
    logic [63:0] word;
    int          nbytes;
    bit          bad;
    int          gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.req_type      <= r.kind;
    req_if.opcode        <= r.opcode;
    req_if.funct3        <= r.funct3;
    req_if.funct7        <= r.funct7;
    req_if.rd_reg        <= r.rd;
    req_if.rs1_reg       <= r.rs1;
    req_if.rs2_reg       <= r.rs2;
    req_if.acc_reg       <= r.acc;
    req_if.immediate     <= r.imm;
    req_if.label_pending <= r.label_pending;
    req_if.operation     <= r.operation;
    req_if.dtype         <= r.dtype;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    encode_instr(r, word, nbytes, bad);
    if (typed) begin
      word = tword;
      bad = terr;
    end
    queue_bytes(word, nbytes, bad);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rsp_if.ready = 1'b0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        hold_req = 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t unexpected byte: expected none, got byte %02h last %0b error %0b",
                 $time, rsp_if.out_byte, rsp_if.last, rsp_if.error);
        fails++;
      end else begin
        if (rsp_if.out_byte !== expected_bytes[0].data ||
            rsp_if.last !== expected_bytes[0].last ||
            rsp_if.error !== expected_bytes[0].err) begin
          $display("%0t mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                   $time, expected_bytes[0].data, expected_bytes[0].last,
                   expected_bytes[0].err, rsp_if.out_byte, rsp_if.last, rsp_if.error);
          fails++;
        end
        void'(expected_bytes.pop_front());
      end
    end
  end

  initial begin
    fails = 0;
    cycle_count = 0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = '0;
    req_if.opcode = '0;
    req_if.funct3 = '0;
    req_if.funct7 = '0;
    req_if.rd_reg = '0;
    req_if.rs1_reg = '0;
    req_if.rs2_reg = '0;
    req_if.acc_reg = '0;
    req_if.immediate = '0;
    req_if.label_pending = 1'b0;
    req_if.operation = '0;
    req_if.dtype = '0;

    add_row(dir_row_t'{mk(REQ_RET, 7'h7f, 3'h7, 7'h7f, 6'h3f, 6'h3f, 6'h3f,
      6'h3f, 64'hffff_ffff_ffff_ffff, 1'b1, 8'hff, 16'hffff), 1'b1, 64'h0000_8067, 1'b0});
    add_row(dir_row_t'{mk(REQ_LI, 7'h00, 3'h0, 7'h00, 6'h00, 6'h3f, 6'h3f,
      6'h3f, 64'hffff_ffff_ffff_f800, 1'b1, 8'h00, 16'h0000), 1'b1, 64'h8000_0013, 1'b0});
    add_row(dir_row_t'{mk(REQ_LI, 7'h7f, 3'h7, 7'h7f, 6'h1f, 6'h00, 6'h00,
      6'h00, 64'h0000_0000_0000_07ff, 1'b0, 8'hff, 16'hffff), 1'b1, 64'h7ff0_0f93, 1'b0});
    add_row(dir_row_t'{mk(REQ_LI, 7'h00, 3'h0, 7'h00, 6'h01, 6'h00, 6'h00,
      6'h00, 64'h0000_0000_0000_0800, 1'b0, 8'h00, 16'h0000), 1'b1, 64'h0, 1'b1});
    add_row(dir_row_t'{mk(REQ_WIDE, 7'h7f, 3'h7, 7'h00, 6'h20, 6'h20, 6'h20,
      6'h20, 64'hffff_ffff_ffff_ffff, 1'b1, 8'h00, 16'h0000), 1'b1, 64'h3f, 1'b0});
    add_row(dir_row_t'{mk(REQ_WIDE, 7'h00, 3'h0, 7'h7f, 6'h3f, 6'h3f, 6'h3f,
      6'h3f, 64'h0, 1'b0, 8'hff, 16'hffff), 1'b1, 64'hffff_1fff_ffff_8fbf, 1'b0});
    add_row(dir_row_t'{mk(REQ_WIDE, 7'h00, 3'h0, 7'h11, 6'h3f, 6'h3f, 6'h3f,
      6'h1f, 64'h0, 1'b0, 8'h5a, 16'h1234), 1'b1, 64'h0, 1'b1});
    add_row(dir_row_t'{mk(REQ_R, 7'h7f, 3'h7, 7'h7f, 6'h1f, 6'h1f, 6'h1f,
      6'h3f, 64'hffff_ffff_ffff_ffff, 1'b1, 8'hff, 16'hffff), 1'b0, '0, 1'b0});
    add_row(dir_row_t'{mk(REQ_R, 7'h33, 3'h0, 7'h20, 6'h05, 6'h06, 6'h27,
      6'h00, 64'h0, 1'b0, 8'h00, 16'h0000), 1'b1, 64'h0, 1'b1});
    add_row(dir_row_t'{mk(REQ_I, 7'h03, 3'h3, 7'h7f, 6'h0a, 6'h1f, 6'h3f,
      6'h3f, 64'hffff_ffff_ffff_f800, 1'b1, 8'h00, 16'h0000), 1'b0, '0, 1'b0});
    add_row(dir_row_t'{mk(REQ_I, 7'h13, 3'h0, 7'h00, 6'h01, 6'h02, 6'h00,
      6'h00, 64'h7fff_ffff_ffff_ffff, 1'b0, 8'h00, 16'h0000), 1'b1, 64'h0, 1'b1});
    add_row(dir_row_t'{mk(REQ_S, 7'h23, 3'h3, 7'h00, 6'h3f, 6'h1f, 6'h1e,
      6'h00, 64'h0000_0000_0000_07ff, 1'b0, 8'h00, 16'h0000), 1'b0, '0, 1'b0});
    add_row(dir_row_t'{mk(REQ_S, 7'h23, 3'h2, 7'h00, 6'h00, 6'h01, 6'h02,
      6'h00, 64'hffff_ffff_ffff_f7ff, 1'b0, 8'h00, 16'h0000), 1'b1, 64'h0, 1'b1});
    add_row(dir_row_t'{mk(REQ_U, 7'h37, 3'h7, 7'h7f, 6'h1f, 6'h3f, 6'h3f,
      6'h3f, 64'hffff_ffff_fff8_0000, 1'b0, 8'h00, 16'h0000), 1'b0, '0, 1'b0});
    add_row(dir_row_t'{mk(REQ_U, 7'h17, 3'h0, 7'h00, 6'h02, 6'h00, 6'h00,
      6'h00, 64'h0000_0000_0007_ffff, 1'b0, 8'h00, 16'h0000), 1'b0, '0, 1'b0});
    add_row(dir_row_t'{mk(REQ_BRANCH, 7'h00, 3'h1, 7'h00, 6'h3f, 6'h1f, 6'h1f,
      6'h3f, 64'hffff_ffff_ffff_f000, 1'b0, 8'h00, 16'h0000), 1'b0, '0, 1'b0});
    add_row(dir_row_t'{mk(REQ_BRANCH, 7'h7f, 3'h5, 7'h00, 6'h00, 6'h03, 6'h04,
      6'h00, 64'h0000_0000_0000_0ffe, 1'b0, 8'h00, 16'h0000), 1'b0, '0, 1'b0});
    add_row(dir_row_t'{mk(REQ_BRANCH, 7'h00, 3'h0, 7'h00, 6'h00, 6'h01, 6'h02,
      6'h00, 64'h0000_0000_0000_0003, 1'b0, 8'h00, 16'h0000), 1'b1, 64'h0, 1'b1});
    add_row(dir_row_t'{mk(REQ_BRANCH, 7'h00, 3'h0, 7'h00, 6'h00, 6'h01, 6'h02,
      6'h00, 64'h0000_0000_0000_1000, 1'b0, 8'h00, 16'h0000), 1'b1, 64'h0, 1'b1});
    add_row(dir_row_t'{mk(REQ_BRANCH, 7'h00, 3'h0, 7'h00, 6'h00, 6'h01, 6'h02,
      6'h00, 64'h0000_0000_0000_0010, 1'b1, 8'h00, 16'h0000), 1'b1, 64'h0, 1'b1});
    add_row(dir_row_t'{mk(REQ_JUMP, 7'h13, 3'h7, 7'h7f, 6'h1f, 6'h3f, 6'h3f,
      6'h3f, 64'hffff_ffff_fff0_0000, 1'b0, 8'hff, 16'hffff), 1'b0, '0, 1'b0});
    add_row(dir_row_t'{mk(REQ_JUMP, 7'h00, 3'h0, 7'h00, 6'h01, 6'h00, 6'h00,
      6'h00, 64'h0000_0000_000f_fffe, 1'b0, 8'h00, 16'h0000), 1'b0, '0, 1'b0});
    add_row(dir_row_t'{mk(REQ_JUMP, 7'h00, 3'h0, 7'h00, 6'h01, 6'h00, 6'h00,
      6'h00, 64'h0000_0000_0000_0101, 1'b0, 8'h00, 16'h0000), 1'b1, 64'h0, 1'b1});
    add_row(dir_row_t'{mk(REQ_JUMP, 7'h00, 3'h0, 7'h00, 6'h01, 6'h00, 6'h00,
      6'h00, 64'h0000_0000_0000_0100, 1'b1, 8'h00, 16'h0000), 1'b1, 64'h0, 1'b1});
    add_row(dir_row_t'{mk(REQ_UNDEF_LO, 7'h13, 3'h0, 7'h00, 6'h00, 6'h00, 6'h00,
      6'h00, 64'h0, 1'b0, 8'h00, 16'h0000), 1'b1, 64'h0, 1'b1});
    add_row(dir_row_t'{mk(REQ_UNDEF_HI, 7'h7f, 3'h7, 7'h7f, 6'h3f, 6'h3f, 6'h3f,
      6'h3f, 64'hffff_ffff_ffff_ffff, 1'b1, 8'hff, 16'hffff), 1'b1, 64'h0, 1'b1});

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_instr(dir_rows[i].instr, dir_rows[i].typed, dir_rows[i].word, dir_rows[i].err);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == PRESSURE_AT) hold_req = 1'b1;
      if (n == QUIET_FROM) idle_en = 1'b0;
      send_instr(rand_instr(), 1'b0, '0, 1'b0);
    end
    @(negedge clk_i);
    req_if.valid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== rv64_instruction_word_encoder.f =====
rtl/core/rvenc_pkg.sv
rtl/core/rvenc_if.sv
rtl/core/rvenc_front.sv
rtl/core/rvenc_queue.sv
rtl/core/rvenc_back.sv
rtl/core/rv64_instruction_word_encoder.sv
sim/rv64_instruction_word_encoder_tb.sv
